@@ rtl/pcs_pkg.sv @@
package pcs_pkg;

  localparam int COORD_BITS = 24;
  localparam int D_W        = COORD_BITS + 1;      // coordinate difference
  localparam int SEG_W      = COORD_BITS + 2;      // segment length
  localparam int RAD_W      = 2 * SEG_W;           // square root radicand
  localparam int REM_W      = SEG_W + 2;           // square root remainder
  localparam int CNT_W      = $clog2(SEG_W);
  localparam int COS_W      = 18;
  localparam int LEN_W      = 32;
  localparam int TOT_W      = 40;
  localparam int KEPT_W     = 16;
  localparam int MUL_W      = SEG_W;
  localparam int DOT_SHIFT  = 16;
  localparam int ACC_W      = 2 * COORD_BITS + 22; // dot*2^16 - cos*La*Lb
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [ADDR_W-1:0] ADDR_MIN_LENGTH = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_COS_LIMIT  = 3'd4;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 32'd1024;
  localparam logic [COS_W-1:0] COS_LIMIT_RST  = 18'd52;

  localparam logic [1:0] SPLIT_NONE = 2'd0;
  localparam logic [1:0] SPLIT_KEEP = 2'd1;
  localparam logic [1:0] SPLIT_DROP = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         end_of_path;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        split_code;
    logic [TOT_W-1:0]  closed_length;
    logic [KEPT_W-1:0] kept_count;
    logic              is_final;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic clr;
  } mac_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_TOTAL,
    S_CS,
    S_RHS,
    S_DX,
    S_DY,
    S_FIN
  } state_t;

  function automatic logic [D_W-1:0] mag_d(logic signed [D_W-1:0] v);
    return v[D_W-1] ? D_W'(-v) : D_W'(v);
  endfunction

  function automatic logic [COS_W-1:0] mag_c(logic signed [COS_W-1:0] v);
    return v[COS_W-1] ? COS_W'(-v) : COS_W'(v);
  endfunction

endpackage

@@ rtl/pcs_mac.sv @@
module pcs_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcs_pkg::mac_cmd_t              cmd,
  input  logic signed [pcs_pkg::ACC_W-1:0] mcand_in,
  input  logic [pcs_pkg::MUL_W-1:0]      mult_in,
  output logic                           busy,
  output logic signed [pcs_pkg::ACC_W-1:0] acc
);
  import pcs_pkg::*;

  logic signed [ACC_W-1:0] mcand_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [MUL_W-1:0]        mult_r;

  // One multiplier bit is consumed per cycle; the run ends once no set bits remain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= '0;
    end else if (cmd.start) begin
      mult_r <= mult_in;
    end else if (mult_r != '0) begin
      mult_r <= mult_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mcand_r <= mcand_in;
      if (cmd.clr) begin
        acc_r <= '0;
      end
    end else if (mult_r != '0) begin
      mcand_r <= mcand_r <<< 1;
      if (mult_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
    end
  end

  assign busy = (mult_r != '0);
  assign acc  = acc_r;

endmodule

@@ rtl/path_cusp_segmenter.sv @@
// From the accepting edge to out_valid: the first point of a path goes straight to S_FIN, and
// the second runs S_SQX and S_SQY (squares of |dx| and |dy|), S_SQRT and S_TOTAL.
// From the third point on, S_CS, S_RHS, S_DX and S_DY follow if both segment lengths are nonzero;
// each serial multiply runs until its multiplier is zero. A point waits in S_FIN while the
// output is held. Throughput: one point at a time, the next taken in the cycle after the result
// is registered. Synchronous active-low reset clears the path state, FSM, config and out_valid.
module path_cusp_segmenter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pcs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pcs_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcs_pkg::ADDR_W-1:0]    paddr,
  input  logic [pcs_pkg::DATA_W-1:0]    pwdata,
  output logic [pcs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import pcs_pkg::*;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]               min_len_r;
  logic signed [COS_W-1:0]        cos_r;

  logic signed [COORD_BITS-1:0]   x_r, y_r;
  logic                           fin_r;
  logic signed [D_W-1:0]          ax_r, ay_r, bx_r, by_r;
  logic signed [COORD_BITS-1:0]   prev_x_r, prev_y_r, older_x_r, older_y_r;
  logic [SEG_W-1:0]               prev_len_r;
  logic [1:0]                     ps_r;
  logic [TOT_W-1:0]               total_r;
  logic [KEPT_W-1:0]              kept_r;

  logic [RAD_W-1:0]               rad_r;
  logic [REM_W-1:0]               rem_r;
  logic [SEG_W-1:0]               root_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           chk_r;

  logic                           out_valid_r;
  out_item_t                      out_data_r;

  mac_cmd_t                       mac_cmd;
  logic signed [ACC_W-1:0]        mac_mcand;
  logic [MUL_W-1:0]               mac_mult;
  logic                           mac_busy;
  logic signed [ACC_W-1:0]        mac_acc;

  logic                           accept;
  logic                           out_free;
  logic                           cfg_wr;

  logic [REM_W+1:0]               rem_sh;
  logic [REM_W+1:0]               trial;
  logic                           ge;
  logic [TOT_W:0]                 tot_sum;

  logic                           split;
  logic                           keep;
  logic [KEPT_W-1:0]              kept_new;
  logic [KEPT_W-1:0]              kept_out;
  logic [TOT_W-1:0]               closed;
  logic [1:0]                     code;

  logic signed [ACC_W-1:0]        ax_ext, ay_ext;
  logic signed [D_W-1:0]          ax_in;

  pcs_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mac_cmd),
    .mcand_in (mac_mcand),
    .mult_in  (mac_mult),
    .busy     (mac_busy),
    .acc      (mac_acc)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_comb begin
    case (paddr)
      ADDR_MIN_LENGTH: prdata = min_len_r;
      ADDR_COS_LIMIT:  prdata = {{(DATA_W-COS_W){cos_r[COS_W-1]}}, cos_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LENGTH_RST;
      cos_r     <= COS_LIMIT_RST;
    end else if (cfg_wr) begin
      if (paddr == ADDR_MIN_LENGTH) begin
        min_len_r <= pwdata[LEN_W-1:0];
      end else if (paddr == ADDR_COS_LIMIT) begin
        cos_r <= pwdata[COS_W-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (ps_r == 2'd0) ? S_FIN : S_SQX;
        end
      end
      S_SQX:   if (!mac_busy) state_nxt = S_SQY;
      S_SQY:   if (!mac_busy) state_nxt = S_SQRT;
      S_SQRT:  if (cnt_r == CNT_W'(SEG_W - 1)) state_nxt = S_TOTAL;
      S_TOTAL: begin
        if (ps_r == 2'd2 && root_r != '0 && prev_len_r != '0) begin
          state_nxt = S_CS;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CS:    if (!mac_busy) state_nxt = S_RHS;
      S_RHS:   if (!mac_busy) state_nxt = S_DX;
      S_DX:    if (!mac_busy) state_nxt = S_DY;
      S_DY:    if (!mac_busy) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ax_ext = {{(ACC_W-D_W){ax_r[D_W-1]}}, ax_r};
  assign ay_ext = {{(ACC_W-D_W){ay_r[D_W-1]}}, ay_r};

  // The first multiply starts on the accepting edge, so it takes dx straight from the input beat.
  assign ax_in = D_W'(in_data.pos_x) - D_W'(prev_x_r);

  // A multiplication is launched on entry to each of the MAC states.
  always_comb begin
    mac_cmd.start = 1'b0;
    mac_cmd.clr   = 1'b0;
    mac_mcand     = '0;
    mac_mult      = '0;
    if (state_nxt != state_r) begin
      case (state_nxt)
        S_SQX: begin
          mac_cmd.start = 1'b1;
          mac_cmd.clr   = 1'b1;
          mac_mcand     = ACC_W'(mag_d(ax_in));
          mac_mult      = MUL_W'(mag_d(ax_in));
        end
        S_SQY: begin
          mac_cmd.start = 1'b1;
          mac_mcand     = ACC_W'(mag_d(ay_r));
          mac_mult      = MUL_W'(mag_d(ay_r));
        end
        S_CS: begin
          mac_cmd.start = 1'b1;
          mac_cmd.clr   = 1'b1;
          mac_mcand     = ACC_W'(root_r);
          mac_mult      = MUL_W'(mag_c(cos_r));
        end
        S_RHS: begin
          // The accumulator ends up holding dot*2^16 minus cos_limit*La*Lb.
          mac_cmd.start = 1'b1;
          mac_cmd.clr   = 1'b1;
          mac_mcand     = cos_r[COS_W-1] ? mac_acc : -mac_acc;
          mac_mult      = prev_len_r;
        end
        S_DX: begin
          mac_cmd.start = 1'b1;
          mac_mcand     = bx_r[D_W-1] ? -(ax_ext <<< DOT_SHIFT) : (ax_ext <<< DOT_SHIFT);
          mac_mult      = MUL_W'(mag_d(bx_r));
        end
        S_DY: begin
          mac_cmd.start = 1'b1;
          mac_mcand     = by_r[D_W-1] ? -(ay_ext <<< DOT_SHIFT) : (ay_ext <<< DOT_SHIFT);
          mac_mult      = MUL_W'(mag_d(by_r));
        end
        default: begin
          mac_cmd.start = 1'b0;
        end
      endcase
    end
  end

  // Square root: two radicand bits per cycle, one root bit per cycle.
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign ge     = (rem_sh >= trial);

  assign tot_sum = {1'b0, total_r} + (TOT_W+1)'(root_r);

  assign split    = chk_r && mac_acc[ACC_W-1];
  assign keep     = (total_r > TOT_W'(min_len_r));
  assign kept_new = (split && keep && kept_r != '1) ? kept_r + 1'b1 : kept_r;
  assign kept_out = (fin_r && kept_new != '1) ? kept_new + 1'b1 : kept_new;
  assign code     = !split ? SPLIT_NONE : (keep ? SPLIT_KEEP : SPLIT_DROP);

  always_comb begin
    if (fin_r) begin
      closed = split ? '0 : total_r;
    end else begin
      closed = split ? total_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_data.pos_x;
      y_r    <= in_data.pos_y;
      fin_r  <= in_data.end_of_path;
      ax_r   <= ax_in;
      ay_r   <= D_W'(in_data.pos_y) - D_W'(prev_y_r);
      bx_r   <= D_W'(prev_x_r) - D_W'(older_x_r);
      by_r   <= D_W'(prev_y_r) - D_W'(older_y_r);
    end
    if (state_r == S_SQY && !mac_busy) begin
      rad_r <= mac_acc[RAD_W-1:0];
      rem_r <= '0;
      cnt_r <= '0;
    end else if (state_r == S_SQRT) begin
      rad_r <= rad_r << 2;
      rem_r <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      chk_r  <= 1'b0;
    end else if (accept) begin
      root_r <= '0;
      chk_r  <= 1'b0;
    end else if (state_r == S_SQRT) begin
      root_r <= {root_r[SEG_W-2:0], ge};
    end else if (state_r == S_TOTAL && state_nxt == S_CS) begin
      chk_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      older_x_r  <= '0;
      older_y_r  <= '0;
      prev_len_r <= '0;
      ps_r       <= '0;
      total_r    <= '0;
      kept_r     <= '0;
    end else if (state_r == S_TOTAL && ps_r == 2'd2) begin
      total_r <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
    end else if (state_r == S_FIN && out_free) begin
      if (fin_r) begin
        prev_x_r   <= '0;
        prev_y_r   <= '0;
        older_x_r  <= '0;
        older_y_r  <= '0;
        prev_len_r <= '0;
        ps_r       <= '0;
        total_r    <= '0;
        kept_r     <= '0;
      end else begin
        older_x_r  <= prev_x_r;
        older_y_r  <= prev_y_r;
        prev_x_r   <= x_r;
        prev_y_r   <= y_r;
        prev_len_r <= root_r;
        if (ps_r != 2'd2) begin
          ps_r <= ps_r + 1'b1;
        end
        if (split) begin
          total_r <= '0;
        end
        kept_r <= kept_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r.split_code    <= code;
      out_data_r.closed_length <= closed;
      out_data_r.kept_count    <= kept_out;
      out_data_r.is_final      <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !mac_busy)
    else $error("serial MAC still running outside a multiply state");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free && fin_r) |=> (ps_r == 2'd0 && total_r == '0 && kept_r == '0))
    else $error("path state not cleared after the final point");

  a_kept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.split_code == SPLIT_KEEP && !out_data_r.is_final)
      |-> out_data_r.closed_length != '0)
    else $error("kept subpath reported with zero length");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.split_code == SPLIT_NONE || out_data_r.split_code == SPLIT_KEEP
                     || out_data_r.split_code == SPLIT_DROP))
    else $error("undefined split code on a result beat");

endmodule
